FILE: sv/scfa_pkg.sv
package scfa_pkg;

    // pool geometry and class layout
    localparam int POOL_BYTES    = 32768;
    localparam int NUM_CLASSES   = 9;
    localparam int GRANULE_BYTES = 16;
    localparam int HEADER_BYTES  = 8;

    // field widths
    localparam int ADDR_W  = 15;
    localparam int SIZE_W  = 16;
    localparam int CLASS_W = 4;
    localparam int STAT_W  = 2;

    // derived sizes
    localparam int NUM_GRANULES = POOL_BYTES / GRANULE_BYTES;
    localparam int GRAN_W       = $clog2(NUM_GRANULES);
    localparam int GRAN_SH      = $clog2(GRANULE_BYTES);
    localparam int BUMP_W       = $clog2(POOL_BYTES) + 1;
    localparam int MAX_BLOCK    = GRANULE_BYTES << (NUM_CLASSES - 1);
    localparam int CSIZE_W      = $clog2(MAX_BLOCK) + 1;
    localparam int TOTAL_W      = SIZE_W + 1;
    localparam int LINK_W       = ADDR_W + 1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NULL_FREE = 2'd3
    } t_status;

    // classified request handed from front to back
    typedef struct packed {
        t_op                op;
        logic               too_large;
        logic               null_free;
        logic [CLASS_W-1:0] cls;
        logic [ADDR_W-1:0]  base;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        t_status            status;
        logic [CLASS_W-1:0] bucket;
    } t_res;

endpackage

FILE: sv/scfa_front.sv
module scfa_front
    import scfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_op,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [ADDR_W-1:0] i_free_addr,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    logic [TOTAL_W-1:0] total;
    logic [CLASS_W-1:0] cls;
    t_cmd               cmd_new;
    logic               wr_en;
    logic               rd_en;

    t_cmd               r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;

    // size class: smallest class whose block holds header plus request
    always_comb begin
        total = {1'b0, i_req_size} + TOTAL_W'(HEADER_BYTES);
        cls   = CLASS_W'(NUM_CLASSES - 1);
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (total <= TOTAL_W'(GRANULE_BYTES << k)) begin
                cls = CLASS_W'(k);
            end
        end
    end

    // classified command
    always_comb begin
        cmd_new.op        = t_op'(i_op);
        cmd_new.too_large = total > TOTAL_W'(MAX_BLOCK);
        cmd_new.null_free = i_free_addr == '0;
        cmd_new.cls       = cls;
        cmd_new.base      = (i_free_addr - ADDR_W'(HEADER_BYTES))
                            & ~ADDR_W'(GRANULE_BYTES - 1);
    end

    // two-entry command queue
    assign o_full      = r_cnt == 2'd2;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= cmd_new;
        end
    end

endmodule

FILE: sv/scfa_back.sv
module scfa_back
    import scfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;

    // list heads and bump pointer
    logic [ADDR_W-1:0]   r_head [NUM_CLASSES];
    logic [ADDR_W-1:0]   n_head [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_hv;
    logic [NUM_CLASSES-1:0] n_hv;
    logic [BUMP_W-1:0]   r_bump;
    logic [BUMP_W-1:0]   n_bump;

    // link and tag memories
    logic [LINK_W-1:0]   link_mem [NUM_GRANULES];
    logic [CLASS_W-1:0]  tag_mem  [NUM_GRANULES];
    logic [LINK_W-1:0]   r_link_rd;
    logic [CLASS_W-1:0]  r_tag_rd;
    logic [ADDR_W-1:0]   head_sel;
    logic                link_we;
    logic [GRAN_W-1:0]   link_wa;
    logic [LINK_W-1:0]   link_wd;
    logic                tag_we;
    logic [GRAN_W-1:0]   tag_wa;
    logic [CLASS_W-1:0]  tag_wd;

    // execute helpers
    logic [CLASS_W-1:0]  k_free;
    logic [CSIZE_W-1:0]  csize;
    logic [BUMP_W:0]     bump_sum;
    logic [ADDR_W-1:0]   base;

    // result queue
    t_res                r_rq [2];
    logic                r_rwp;
    logic                r_rrp;
    logic [1:0]          r_rcnt;
    logic [1:0]          n_rcnt;
    logic                res_full;
    logic                res_push;
    logic                res_pop;
    t_res                res;

    // sequencer: read memories on take, update state in the execute state once the result queue has room
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign res_full   = r_rcnt == 2'd2;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
    end

    // memory ports
    assign head_sel = r_head[i_cmd.cls];

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_link_rd <= link_mem[head_sel[GRAN_SH +: GRAN_W]];
            r_tag_rd  <= tag_mem[i_cmd.base[GRAN_SH +: GRAN_W]];
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (tag_we) begin
            tag_mem[tag_wa] <= tag_wd;
        end
    end

    // execute step
    always_comb begin
        k_free   = (r_tag_rd >= CLASS_W'(NUM_CLASSES)) ? CLASS_W'(NUM_CLASSES - 1) : r_tag_rd;
        csize    = CSIZE_W'(GRANULE_BYTES) << r_cmd.cls;
        bump_sum = {1'b0, r_bump} + (BUMP_W + 1)'(csize);
        base     = '0;
        n_head   = r_head;
        n_hv     = r_hv;
        n_bump   = r_bump;
        link_we  = 1'b0;
        link_wa  = r_cmd.base[GRAN_SH +: GRAN_W];
        link_wd  = '0;
        tag_we   = 1'b0;
        tag_wa   = '0;
        tag_wd   = r_cmd.cls;
        res_push = 1'b0;
        res      = '{addr: '0, status: ST_OK, bucket: '0};
        if (r_state == S_EXEC && !res_full) begin
            res_push = 1'b1;
            case (r_cmd.op)
                OP_ALLOC: begin
                    if (r_cmd.too_large) begin
                        res.status = ST_TOO_LARGE;
                    end else if (r_hv[r_cmd.cls]) begin
                        base               = r_head[r_cmd.cls];
                        n_hv[r_cmd.cls]    = r_link_rd[LINK_W-1];
                        n_head[r_cmd.cls]  = r_link_rd[ADDR_W-1:0];
                        tag_we             = 1'b1;
                        tag_wa             = base[GRAN_SH +: GRAN_W];
                        res.addr           = base + ADDR_W'(HEADER_BYTES);
                        res.bucket         = r_cmd.cls;
                    end else if (bump_sum > (BUMP_W + 1)'(POOL_BYTES)) begin
                        res.status = ST_EXHAUSTED;
                        res.bucket = r_cmd.cls;
                    end else begin
                        base       = r_bump[ADDR_W-1:0];
                        n_bump     = bump_sum[BUMP_W-1:0];
                        tag_we     = 1'b1;
                        tag_wa     = base[GRAN_SH +: GRAN_W];
                        res.addr   = base + ADDR_W'(HEADER_BYTES);
                        res.bucket = r_cmd.cls;
                    end
                end
                OP_FREE: begin
                    if (r_cmd.null_free) begin
                        res.status = ST_NULL_FREE;
                    end else begin
                        link_we         = 1'b1;
                        link_wd         = r_hv[k_free] ? {1'b1, r_head[k_free]} : '0;
                        n_head[k_free]  = r_cmd.base;
                        n_hv[k_free]    = 1'b1;
                        res.bucket      = k_free;
                    end
                end
                default: res.status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= '0;
            r_bump <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_hv   <= n_hv;
            r_bump <= n_bump;
            r_head <= n_head;
        end
    end

    // two-entry result queue
    assign o_empty = r_rcnt == 2'd0;
    assign o_res   = r_rq[r_rrp];
    assign res_pop = i_pop && !o_empty;

    always_comb begin
        n_rcnt = r_rcnt;
        if (res_push && !res_pop) begin
            n_rcnt = r_rcnt + 2'd1;
        end else if (res_pop && !res_push) begin
            n_rcnt = r_rcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwp  <= 1'b0;
            r_rrp  <= 1'b0;
            r_rcnt <= 2'd0;
        end else begin
            r_rcnt <= n_rcnt;
            if (res_push) begin
                r_rwp <= ~r_rwp;
            end
            if (res_pop) begin
                r_rrp <= ~r_rrp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rwp] <= res;
        end
    end

    // checks
    a_bump_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= BUMP_W'(POOL_BYTES))
        else $error("bump pointer beyond pool");

    a_bump_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump[GRAN_SH-1:0] == '0)
        else $error("bump pointer not granule aligned");

    a_ok_addr_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.status == ST_OK && o_res.addr != '0)
        |-> o_res.addr[GRAN_SH-1:0] == GRAN_SH'(HEADER_BYTES))
        else $error("allocated address not base plus header");

    a_exec_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> r_state == S_EXEC)
        else $error("taken command not executed");

endmodule

FILE: sv/size_class_free_list_allocator_top.sv
// size class free list allocator
// request channel: push/full with op, req_size and free_addr; a request is
// transferred on a clock edge with push high and full low. result channel:
// empty/pop; while empty is low the oldest result sits on addr_out, status
// and bucket_out, and is transferred on an edge with pop high.
// every request gives exactly one result, in request order.
// timing: the front classifies a request and writes it into the command queue;
// the back takes it from the queue, reads the link and tag memories, and then
// writes the result queue from its execute state, once that queue has room.
// the back takes no new request until it has written the result of the last,
// since it reads a list head's link memory entry before it can update that head.
// a two-entry command queue and a two-entry result queue part the sides;
// when the receiver stops popping, the back holds its current request, the
// command queue fills and full rises; nothing is dropped.
// reset (synchronous, active low) empties both queues, marks every free list
// empty and returns the bump pointer to the pool start; memory contents are
// left as they are; the link memory is only used after being written.
module size_class_free_list_allocator_top
    import scfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_op,
    input  logic [SIZE_W-1:0]  i_req_size,
    input  logic [ADDR_W-1:0]  i_free_addr,
    output logic               empty,
    input  logic               pop,
    output logic [ADDR_W-1:0]  o_addr_out,
    output logic [STAT_W-1:0]  o_status,
    output logic [CLASS_W-1:0] o_bucket_out
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;
    t_res res;

    // classify and queue requests
    scfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_req_size  (i_req_size),
        .i_free_addr (i_free_addr),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // carry out allocates and frees
    scfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    // result fields
    assign o_addr_out   = res.addr;
    assign o_status     = res.status;
    assign o_bucket_out = res.bucket;

endmodule

FILE: tb/tb_size_class_free_list_allocator_top.sv
module tb_size_class_free_list_allocator_top;
    import scfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 300;
    localparam int TAIL_CYCLES = 8;

    // expected results of the allocator, kept in transfer order
    class alloc_scoreboard;
        logic [ADDR_W-1:0] free_head [NUM_CLASSES];
        bit                free_head_valid [NUM_CLASSES];
        logic [LINK_W-1:0] next_link [NUM_GRANULES];
        int                block_class [NUM_GRANULES];
        int                carve_ptr;
        t_res              awaited_results [$];
        int                errors;

        function new();
            foreach (free_head[i]) begin
                free_head[i] = '0;
                free_head_valid[i] = 1'b0;
            end
            foreach (next_link[i]) begin
                next_link[i] = '0;
                block_class[i] = 0;
            end
            carve_ptr = 0;
            errors = 0;
        endfunction

        // work out the result of one accepted request and queue it
        function t_res note_request(t_op op, logic [SIZE_W-1:0] req_size,
                                    logic [ADDR_W-1:0] free_addr);
            t_res              res;
            int                total;
            int                k;
            int                csize;
            logic [ADDR_W-1:0] base;
            logic [GRAN_W-1:0] g;
            logic [LINK_W-1:0] lnk;
            res = '{addr: '0, status: ST_OK, bucket: '0};
            base = '0;
            if (op == OP_ALLOC) begin
                total = int'(req_size) + HEADER_BYTES;
                if (total > MAX_BLOCK) begin
                    res.status = ST_TOO_LARGE;
                end else begin
                    k = 0;
                    while (k + 1 < NUM_CLASSES && (GRANULE_BYTES << k) < total)
                        k++;
                    csize = GRANULE_BYTES << k;
                    res.bucket = CLASS_W'(k);
                    if (free_head_valid[k]) begin
                        // reuse the most recently freed block of this class
                        base = free_head[k];
                        lnk = next_link[GRAN_W'(base >> GRAN_SH)];
                        free_head_valid[k] = lnk[LINK_W-1];
                        free_head[k] = lnk[ADDR_W-1:0];
                    end else if (carve_ptr + csize > POOL_BYTES) begin
                        res.status = ST_EXHAUSTED;
                    end else begin
                        base = ADDR_W'(carve_ptr);
                        carve_ptr += csize;
                    end
                    if (res.status == ST_OK) begin
                        block_class[GRAN_W'(base >> GRAN_SH)] = k;
                        res.addr = ADDR_W'(base + HEADER_BYTES);
                    end
                end
            end else if (free_addr == '0) begin
                res.status = ST_NULL_FREE;
            end else begin
                // push the block back on the list named by its tag
                base = free_addr - ADDR_W'(HEADER_BYTES);
                base[GRAN_SH-1:0] = '0;
                g = GRAN_W'(base >> GRAN_SH);
                k = block_class[g];
                if (k >= NUM_CLASSES)
                    k = NUM_CLASSES - 1;
                next_link[g] = free_head_valid[k] ? {1'b1, free_head[k]} : '0;
                free_head[k] = base;
                free_head_valid[k] = 1'b1;
                res.bucket = CLASS_W'(k);
            end
            awaited_results.push_back(res);
            return res;
        endfunction

        // compare one popped result with the oldest expectation
        function void check_result(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] status,
                                   logic [CLASS_W-1:0] bucket);
            t_res want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result addr %0d status %0d bucket %0d",
                         $time, addr, status, bucket);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (addr !== want.addr) begin
                $display("%0t: addr_out expected %0d actual %0d", $time, want.addr, addr);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (bucket !== want.bucket) begin
                $display("%0t: bucket_out expected %0d actual %0d",
                         $time, want.bucket, bucket);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_op = OP_ALLOC;
    logic [SIZE_W-1:0]  i_req_size = '0;
    logic [ADDR_W-1:0]  i_free_addr = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [ADDR_W-1:0]  o_addr_out;
    logic [STAT_W-1:0]  o_status;
    logic [CLASS_W-1:0] o_bucket_out;

    alloc_scoreboard   sb = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                idle_cycles = 0;
    logic [ADDR_W-1:0] live_addrs [$];
    bit                tag_written [NUM_GRANULES];

    size_class_free_list_allocator_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_req_size   (i_req_size),
        .i_free_addr  (i_free_addr),
        .empty        (empty),
        .pop          (pop),
        .o_addr_out   (o_addr_out),
        .o_status     (o_status),
        .o_bucket_out (o_bucket_out)
    );

    always #5 i_clk = ~i_clk;

    // result side: check each transfer, then decide whether to stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                sb.check_result(o_addr_out, o_status, o_bucket_out);
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // drive one request until it is transferred, then note it
    task automatic send_request(input t_op op, input logic [SIZE_W-1:0] req_size,
                                input logic [ADDR_W-1:0] free_addr);
        int                gap;
        t_res              res;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] live_base;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_req_size <= req_size;
        i_free_addr <= free_addr;
        do @(posedge i_clk); while (full);
        res = sb.note_request(op, req_size, free_addr);
        // track live blocks and tagged granules so frees stay legal
        if (op == OP_ALLOC && res.status == ST_OK) begin
            live_addrs.push_back(res.addr);
            base = res.addr - ADDR_W'(HEADER_BYTES);
            tag_written[GRAN_W'(base >> GRAN_SH)] = 1'b1;
        end else if (op == OP_FREE && free_addr != '0) begin
            base = free_addr - ADDR_W'(HEADER_BYTES);
            base[GRAN_SH-1:0] = '0;
            for (int i = 0; i < live_addrs.size(); i++) begin
                live_base = live_addrs[i] - ADDR_W'(HEADER_BYTES);
                if (live_base == base) begin
                    live_addrs.delete(i);
                    break;
                end
            end
        end
    endtask

    // one random request; counted is low for a null free
    task automatic random_request(output bit counted);
        int                r;
        int                k;
        int                lo;
        int                hi;
        logic [ADDR_W-1:0] fa;
        logic [ADDR_W-1:0] b;
        bit                found;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (live_addrs.size() == 0 || r < 50) begin
            if ($urandom_range(0, 99) < 6) begin
                send_request(OP_ALLOC, SIZE_W'($urandom_range(MAX_BLOCK - HEADER_BYTES + 1,
                             65535)), ADDR_W'($urandom));
            end else begin
                // mostly small classes, a few of the largest
                r = $urandom_range(0, 99);
                k = (r < 55) ? $urandom_range(0, 3) : (r < 88) ? $urandom_range(4, 6)
                                                               : $urandom_range(7, 8);
                hi = (GRANULE_BYTES << k) - HEADER_BYTES;
                lo = (k == 0) ? 0 : (GRANULE_BYTES << (k - 1)) - HEADER_BYTES + 1;
                send_request(OP_ALLOC, SIZE_W'($urandom_range(lo, hi)), ADDR_W'($urandom));
            end
        end else if (r < 90) begin
            // free a live block, sometimes from inside its first granule
            fa = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            if ($urandom_range(0, 99) < 30)
                fa = fa + ADDR_W'($urandom_range(0, GRANULE_BYTES - 1));
            send_request(OP_FREE, SIZE_W'($urandom), fa);
        end else if (r < 94) begin
            counted = 1'b0;
            send_request(OP_FREE, SIZE_W'($urandom), '0);
        end else begin
            // stray free of any tagged granule, double frees included
            found = 1'b0;
            fa = '0;
            for (int t = 0; t < 40 && !found; t++) begin
                fa = ADDR_W'($urandom_range(1, (1 << ADDR_W) - 1));
                b = fa - ADDR_W'(HEADER_BYTES);
                found = tag_written[GRAN_W'(b >> GRAN_SH)];
            end
            if (!found) begin
                fa = '0;
                counted = 1'b0;
            end
            send_request(OP_FREE, SIZE_W'($urandom), fa);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] first_addr;
        logic [ADDR_W-1:0] second_addr;
        logic [ADDR_W-1:0] big_addr;
        logic [ADDR_W-1:0] loop_addr;
        int                n;
        bit                counted;
        foreach (tag_written[i])
            tag_written[i] = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size extremes, class edges, null free, reuse, double free
        send_request(OP_ALLOC, 16'd0, 15'h7FFF);
        first_addr = live_addrs[$];
        send_request(OP_ALLOC, 16'd8, '0);
        second_addr = live_addrs[$];
        send_request(OP_ALLOC, 16'd9, '0);
        send_request(OP_ALLOC, SIZE_W'(MAX_BLOCK - HEADER_BYTES), '0);
        big_addr = live_addrs[$];
        send_request(OP_ALLOC, SIZE_W'(MAX_BLOCK - HEADER_BYTES + 1), '0);
        send_request(OP_ALLOC, 16'hFFFF, '0);
        send_request(OP_FREE, 16'hFFFF, '0);
        send_request(OP_FREE, '0, first_addr);
        send_request(OP_FREE, '0, second_addr + ADDR_W'(GRANULE_BYTES - 1));
        send_request(OP_ALLOC, 16'd1, '0);
        send_request(OP_ALLOC, 16'd5, '0);
        send_request(OP_ALLOC, 16'd5, '0);
        send_request(OP_FREE, '0, big_addr);
        send_request(OP_ALLOC, 16'd4000, '0);
        send_request(OP_ALLOC, 16'd100, '0);
        send_request(OP_ALLOC, 16'd500, '0);
        send_request(OP_ALLOC, 16'd2000, '0);
        loop_addr = live_addrs[$];
        send_request(OP_FREE, '0, loop_addr);
        send_request(OP_FREE, '0, loop_addr);
        send_request(OP_ALLOC, 16'd2000, '0);
        send_request(OP_ALLOC, 16'd1500, '0);

        // random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                random_request(counted);
                if (counted)
                    n++;
            end
        end
        push <= 1'b0;

        // drain the result queue, then allow the pipeline to settle
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
